// ===== hdl/bf3_pkg.sv =====
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared constants, types and helpers for the 3x3 box filter stream unit.
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int HEIGHT_MAX = 4096;

  localparam int PIX_W   = 8;
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(HEIGHT_MAX);
  localparam int WCFG_W  = 11;
  localparam int HCFG_W  = 13;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 13;
  localparam int SUM_W   = 12;
  localparam int LINE_W  = 2 * PIX_W;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [HCFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Reciprocal of nine: floor(s * 3641 / 2^15) == floor(s / 9) for s < 2304
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;
  localparam int PROD_W     = 24;

  // Pixel headed for the window stage
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] pixel;
    logic             active;    // row 2 or later: results are due
    logic             col_one;   // left border column of the output row
    logic             interior;  // column 2 or later: a mean is due
    logic             last_col;
    logic             last_row;
  } scan_item_t;

  // Result word waiting in the output queue
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             border;
    logic             row_end;
    logic             frame_end;
  } res_word_t;

  function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(s) * PROD_W'(DIV9_MUL);
    return prod[DIV9_SHIFT +: PIX_W];
  endfunction

endpackage

// ===== hdl/bf3_in_if.sv =====
// ----------------------------------------------------------------------------
// bf3_in_if
// Input pixel channel: valid/ready handshake with one grey pixel per word.
// ----------------------------------------------------------------------------
interface bf3_in_if;
  logic                       valid;
  logic                       ready;
  logic [bf3_pkg::PIX_W-1:0]  pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== hdl/bf3_out_if.sv =====
// ----------------------------------------------------------------------------
// bf3_out_if
// Output result channel: filtered pixel with row and frame end marks.
// ----------------------------------------------------------------------------
interface bf3_out_if;
  logic                       valid;
  logic                       ready;
  logic [bf3_pkg::PIX_W-1:0]  pixel_out;
  logic                       row_end;
  logic                       frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                  output ready);
endinterface

// ===== hdl/bf3_scan.sv =====
// ----------------------------------------------------------------------------
// bf3_scan
// Configuration registers and raster position counters. Tags each accepted
// pixel with its column and its role in the output frame.
// ----------------------------------------------------------------------------
module bf3_scan (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bf3_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CDATA_W-1:0] cfg_data,
  input  logic                        take,
  input  logic [bf3_pkg::PIX_W-1:0]   pixel,
  output bf3_pkg::scan_item_t         item,
  output logic                        restart
);
  import bf3_pkg::*;

  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [WCFG_W-1:0] width_eff;
  logic [HCFG_W-1:0] height_eff;
  logic [COL_W-1:0]  col_last;
  logic [ROW_W-1:0]  row_last;
  logic              last_col;
  logic              last_row;

  assign restart = cfg_we && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[WCFG_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[HCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size to the supported range
  always_comb begin
    width_eff = image_width;
    if (image_width < WCFG_W'(3)) width_eff = WCFG_W'(3);
    if (image_width > WCFG_W'(MAX_WIDTH)) width_eff = WCFG_W'(MAX_WIDTH);
    height_eff = image_height;
    if (image_height < HCFG_W'(3)) height_eff = HCFG_W'(3);
    if (image_height > HCFG_W'(HEIGHT_MAX)) height_eff = HCFG_W'(HEIGHT_MAX);
  end

  assign col_last = COL_W'(width_eff - WCFG_W'(1));
  assign row_last = ROW_W'(height_eff - HCFG_W'(1));
  assign last_col = (column_count == col_last);
  assign last_row = (row_count == row_last);

  // Tag the incoming word
  always_comb begin
    item.col      = column_count;
    item.pixel    = pixel;
    item.active   = (row_count >= ROW_W'(2));
    item.col_one  = (column_count == COL_W'(1));
    item.interior = (column_count >= COL_W'(2));
    item.last_col = last_col;
    item.last_row = last_row;
  end

  // Advance the raster position, wrap at the end of a frame
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (take) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

endmodule

// ===== hdl/bf3_window.sv =====
// ----------------------------------------------------------------------------
// bf3_window
// Line store memory holding the two previous rows, the 3x3 window columns
// and the nine-pixel sum. Reads a column when a word is taken, writes the
// shifted column back on advance and emits up to two result words.
// ----------------------------------------------------------------------------
module bf3_window (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 restart,
  input  logic                 take,
  input  bf3_pkg::scan_item_t  item,
  output logic                 ready,
  input  logic                 push_room,
  output logic [1:0]           push_count,
  output bf3_pkg::res_word_t   word0,
  output bf3_pkg::res_word_t   word1
);
  import bf3_pkg::*;

  // Upper byte: row r-2, lower byte: row r-1
  logic [LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [LINE_W-1:0] line_rd;
  logic              s2_valid;
  scan_item_t        s2;
  logic [PIX_W-1:0]  window_regs [6];
  logic [PIX_W-1:0]  top;
  logic [PIX_W-1:0]  mid;
  logic              advance;
  logic              emit_mean;
  logic              emit_end;
  logic [SUM_W-1:0]  sum;
  res_word_t         mean_word;
  res_word_t         end_word;

  assign top     = line_rd[LINE_W-1:PIX_W];
  assign mid     = line_rd[PIX_W-1:0];
  assign advance = s2_valid && push_room;
  assign ready   = !s2_valid || advance;

  // Read on take, write back the shifted column on advance. Consecutive
  // words touch distinct columns since the width is at least three.
  always_ff @(posedge clk) begin
    if (take) begin
      line_rd <= line_mem[item.col];
    end
    if (advance) begin
      line_mem[s2.col] <= {mid, s2.pixel};
    end
  end

  // Hold the word under work
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (take) begin
      s2_valid <= 1'b1;
    end else if (advance) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2 <= item;
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < 6; i++) window_regs[i] <= '0;
    end else if (advance) begin
      window_regs[0] <= window_regs[3];
      window_regs[1] <= window_regs[4];
      window_regs[2] <= window_regs[5];
      window_regs[3] <= top;
      window_regs[4] <= mid;
      window_regs[5] <= s2.pixel;
    end
  end

  // Nine-pixel sum
  always_comb begin
    sum = SUM_W'(top) + SUM_W'(mid) + SUM_W'(s2.pixel);
    for (int i = 0; i < 6; i++) sum = sum + SUM_W'(window_regs[i]);
  end

  assign emit_mean = advance && s2.active && (s2.col_one || s2.interior);
  assign emit_end  = advance && s2.active && s2.last_col;

  always_comb begin
    mean_word.sum       = sum;
    mean_word.border    = s2.col_one;
    mean_word.row_end   = 1'b0;
    mean_word.frame_end = 1'b0;
    end_word.sum        = '0;
    end_word.border     = 1'b1;
    end_word.row_end    = 1'b1;
    end_word.frame_end  = s2.last_row;
  end

  // Order the result words: mean first, then the right border
  always_comb begin
    word0      = emit_mean ? mean_word : end_word;
    word1      = end_word;
    push_count = 2'(emit_mean) + 2'(emit_end);
  end

endmodule

// ===== hdl/bf3_out_queue.sv =====
// ----------------------------------------------------------------------------
// bf3_out_queue
// Four-word result queue in front of the output channel. Accepts up to two
// words per cycle, scales the head sum by one ninth, or zero for a border.
// ----------------------------------------------------------------------------
module bf3_out_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          push_count,
  input  bf3_pkg::res_word_t  word0,
  input  bf3_pkg::res_word_t  word1,
  output logic                push_room,
  bf3_out_if.source           results
);
  import bf3_pkg::*;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  res_word_t          queue [QDEPTH];
  logic [QPTR_W-1:0]  head;
  logic [QPTR_W-1:0]  tail;
  logic [QPTR_W:0]    count;
  logic               pop;
  res_word_t          head_word;

  assign pop       = results.valid && results.ready;
  assign push_room = (count <= (QPTR_W+1)'(QDEPTH - 2));

  // Store pushed words at the tail
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      queue[tail] <= word0;
    end
    if (push_count == 2'd2) begin
      queue[tail + QPTR_W'(1)] <= word1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + QPTR_W'(push_count);
      if (pop) head <= head + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(push_count) - (QPTR_W+1)'(pop);
    end
  end

  // Drive the head word
  assign head_word         = queue[head];
  assign results.valid     = (count != '0);
  assign results.pixel_out = head_word.border ? '0 : div9(head_word.sum);
  assign results.row_end   = head_word.row_end;
  assign results.frame_end = head_word.frame_end;

endmodule

// ===== hdl/box_filter_3x3_stream_unit.sv =====
// ----------------------------------------------------------------------------
// box_filter_3x3_stream_unit
// 3x3 mean filter over a raster stream of 8-bit grey pixels.
// ----------------------------------------------------------------------------
// Takes one pixel per clock in raster order and returns a frame of
// (height - 2) rows of width pixels: each interior pixel is the truncated
// mean of its 3x3 neighborhood, and the first and last column of every row
// are zero, the last one marked with row_end (and frame_end on the final
// row). The two previous rows live in one 1024 x 16 line store memory that
// is read when a pixel is taken and written back when the pixel's result
// words enter a four-word output queue. With an empty queue the first result
// word of a pixel passes the held word register and then the queue before
// it is offered on the output. The sustained rate is one pixel
// per clock; input is held off while the queue holds three or more words,
// which happens only when the output side stalls, and for as long as that
// lasts. Writing image_width or image_height restarts the frame.
// ----------------------------------------------------------------------------
module box_filter_3x3_stream_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bf3_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [bf3_pkg::CDATA_W-1:0] cfg_data,
  bf3_in_if.sink                      pixels,
  bf3_out_if.source                   results
);
  import bf3_pkg::*;

  scan_item_t item;
  logic       restart;
  logic       take;
  logic       win_ready;
  logic       push_room;
  logic [1:0] push_count;
  res_word_t  word0;
  res_word_t  word1;

  assign pixels.ready = win_ready;
  assign take         = pixels.valid && win_ready;

  bf3_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .pixel     (pixels.pixel_in),
    .item      (item),
    .restart   (restart)
  );

  bf3_window u_window (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .take       (take),
    .item       (item),
    .ready      (win_ready),
    .push_room  (push_room),
    .push_count (push_count),
    .word0      (word0),
    .word1      (word1)
  );

  bf3_out_queue u_out_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .word0      (word0),
    .word1      (word1),
    .push_room  (push_room),
    .results    (results)
  );

endmodule
